// File: hw/rtl/fppu_pkg.sv
package fppu_pkg;

   localparam int unsigned POS_W     = 32;
   localparam int unsigned HEAD_W    = 8;
   localparam int unsigned Q14_W     = 16;
   localparam int unsigned ALPHA_W   = 17;
   localparam int unsigned RADIUS_W  = 31;
   localparam int unsigned SNAP_SHIFT = 8;
   localparam int unsigned TRIG_SHIFT = 14;
   localparam int unsigned ALPHA_SHIFT = 16;
   localparam int unsigned RADIUS8_W = RADIUS_W - SNAP_SHIFT;
   localparam int unsigned SNAP_SQ_W = 2 * RADIUS8_W;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic signed [Q14_W-1:0] Q14_STRAIGHT = 16'sd16384;
   localparam logic signed [Q14_W-1:0] Q14_DIAGONAL = 16'sd11585;
   localparam logic [HEAD_W-1:0]       QUARTER_TURN = 8'd64;
   localparam logic [ALPHA_W-1:0]      ALPHA_RESET  = 17'd3277;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH_ALPHA = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SNAP_RADIUS  = 1'b1;

   typedef enum logic [2:0] {
      MODE_SET       = 3'd0,
      MODE_TRANSLATE = 3'd1,
      MODE_ROTATE    = 3'd2,
      MODE_FORWARD   = 3'd3,
      MODE_SMOOTH    = 3'd4,
      MODE_ADAPTIVE  = 3'd5,
      MODE_DIRECTION = 3'd6,
      MODE_NONE      = 3'd7
   } mode_type;

   typedef struct packed {
      mode_type                 mode;
      logic signed [POS_W-1:0]  value_x;
      logic signed [POS_W-1:0]  value_y;
      logic [HEAD_W-1:0]        angle_value;
      logic signed [POS_W-1:0]  move_distance;
      logic [3:0]               direction;
   } item_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [HEAD_W-1:0]       heading;
   } pose_type;

   typedef struct packed {
      logic [ALPHA_W-1:0]   smooth_alpha;
      logic [SNAP_SQ_W-1:0] snap_sq;
   } cfg_type;

   // first quarter of the sine wave in q1.14, angles 0 to 64
   localparam logic signed [Q14_W-1:0] QUARTER_SINE [65] = '{
      16'sd0,     16'sd402,   16'sd804,   16'sd1205,  16'sd1606,  16'sd2006,
      16'sd2404,  16'sd2801,  16'sd3196,  16'sd3590,  16'sd3981,  16'sd4370,
      16'sd4756,  16'sd5139,  16'sd5520,  16'sd5897,  16'sd6270,  16'sd6639,
      16'sd7005,  16'sd7366,  16'sd7723,  16'sd8076,  16'sd8423,  16'sd8765,
      16'sd9102,  16'sd9434,  16'sd9760,  16'sd10080, 16'sd10394, 16'sd10702,
      16'sd11003, 16'sd11297, 16'sd11585, 16'sd11866, 16'sd12140, 16'sd12406,
      16'sd12665, 16'sd12916, 16'sd13160, 16'sd13395, 16'sd13623, 16'sd13842,
      16'sd14053, 16'sd14256, 16'sd14449, 16'sd14635, 16'sd14811, 16'sd14978,
      16'sd15137, 16'sd15286, 16'sd15426, 16'sd15557, 16'sd15679, 16'sd15791,
      16'sd15893, 16'sd15986, 16'sd16069, 16'sd16143, 16'sd16207, 16'sd16261,
      16'sd16305, 16'sd16340, 16'sd16364, 16'sd16379, 16'sd16384
   };

   // full-turn sine from the quarter table by symmetry
   function automatic logic signed [Q14_W-1:0] sine_q14(input logic [HEAD_W-1:0] angle);
      logic [6:0]              idx;
      logic signed [Q14_W-1:0] mag;
      if (angle[6]) begin
         idx = 7'(8'd128 - {1'b0, angle[6:0]});
      end else begin
         idx = {1'b0, angle[5:0]};
      end
      mag = QUARTER_SINE[idx];
      return angle[7] ? -mag : mag;
   endfunction

   function automatic logic signed [Q14_W-1:0] step_x_q14(input logic [2:0] dir);
      logic signed [Q14_W-1:0] v;
      unique case (dir)
         3'd0:    v = Q14_STRAIGHT;
         3'd1:    v = Q14_DIAGONAL;
         3'd2:    v = '0;
         3'd3:    v = -Q14_DIAGONAL;
         3'd4:    v = -Q14_STRAIGHT;
         3'd5:    v = -Q14_DIAGONAL;
         3'd6:    v = '0;
         default: v = Q14_DIAGONAL;
      endcase
      return v;
   endfunction

   function automatic logic signed [Q14_W-1:0] step_y_q14(input logic [2:0] dir);
      logic signed [Q14_W-1:0] v;
      unique case (dir)
         3'd0:    v = '0;
         3'd1:    v = Q14_DIAGONAL;
         3'd2:    v = Q14_STRAIGHT;
         3'd3:    v = Q14_DIAGONAL;
         3'd4:    v = '0;
         3'd5:    v = -Q14_DIAGONAL;
         3'd6:    v = -Q14_STRAIGHT;
         default: v = -Q14_DIAGONAL;
      endcase
      return v;
   endfunction

endpackage

// File: hw/rtl/fppu_req_if.sv
interface fppu_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [2:0]                            mode;
   logic signed [fppu_pkg::POS_W-1:0]     value_x;
   logic signed [fppu_pkg::POS_W-1:0]     value_y;
   logic [fppu_pkg::HEAD_W-1:0]           angle_value;
   logic signed [fppu_pkg::POS_W-1:0]     move_distance;
   logic [3:0]                            direction;

   modport source (
      output valid, mode, value_x, value_y, angle_value, move_distance, direction,
      input  ready
   );
   modport sink (
      input  valid, mode, value_x, value_y, angle_value, move_distance, direction,
      output ready
   );
endinterface

// File: hw/rtl/fppu_rsp_if.sv
interface fppu_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [fppu_pkg::POS_W-1:0]     pos_x;
   logic signed [fppu_pkg::POS_W-1:0]     pos_y;
   logic [fppu_pkg::HEAD_W-1:0]           heading_out;

   modport source (
      output valid, pos_x, pos_y, heading_out,
      input  ready
   );
   modport sink (
      input  valid, pos_x, pos_y, heading_out,
      output ready
   );
endinterface

// File: hw/rtl/fppu_pose_unit.sv
module fppu_pose_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  fppu_pkg::item_type item,
   input  fppu_pkg::cfg_type  cfg,
   output fppu_pkg::pose_type pose
);

   localparam int unsigned PW = fppu_pkg::POS_W;
   localparam int unsigned QW = fppu_pkg::Q14_W;
   localparam int unsigned D8_W = PW - fppu_pkg::SNAP_SHIFT;
   localparam int unsigned TRIG_PW = QW + PW;
   localparam int unsigned ALPHA_PW = PW + fppu_pkg::ALPHA_W + 1;
   localparam int unsigned SQ_W = 2 * D8_W;

   logic signed [PW-1:0]           x_ff, x_in;
   logic signed [PW-1:0]           y_ff, y_in;
   logic [fppu_pkg::HEAD_W-1:0]    heading_ff, heading_in;

   logic signed [QW-1:0]           coef_x, coef_y;
   logic signed [TRIG_PW-1:0]      trig_x_prod, trig_y_prod;
   logic signed [PW-1:0]           trig_x, trig_y;
   logic signed [PW-1:0]           dx, dy;
   logic signed [fppu_pkg::ALPHA_W:0] alpha_s;
   logic signed [ALPHA_PW-1:0]     alpha_x_prod, alpha_y_prod;
   logic signed [PW-1:0]           alpha_x, alpha_y;
   logic signed [D8_W-1:0]         dx8, dy8;
   logic signed [SQ_W-1:0]         dx_sq, dy_sq;
   logic [SQ_W-1:0]                dist_sq;
   logic                           snap;

   // coefficient pair shared by forward and compass moves
   always_comb begin
      if (item.mode == fppu_pkg::MODE_FORWARD) begin
         coef_x = fppu_pkg::sine_q14(8'(heading_ff + fppu_pkg::QUARTER_TURN));
         coef_y = fppu_pkg::sine_q14(heading_ff);
      end else begin
         coef_x = fppu_pkg::step_x_q14(item.direction[2:0]);
         coef_y = fppu_pkg::step_y_q14(item.direction[2:0]);
      end
   end

   assign trig_x_prod = coef_x * item.move_distance;
   assign trig_y_prod = coef_y * item.move_distance;
   assign trig_x = trig_x_prod[fppu_pkg::TRIG_SHIFT +: PW];
   assign trig_y = trig_y_prod[fppu_pkg::TRIG_SHIFT +: PW];

   assign dx = item.value_x - x_ff;
   assign dy = item.value_y - y_ff;

   assign alpha_s = {1'b0, cfg.smooth_alpha};
   assign alpha_x_prod = dx * alpha_s;
   assign alpha_y_prod = dy * alpha_s;
   assign alpha_x = alpha_x_prod[fppu_pkg::ALPHA_SHIFT +: PW];
   assign alpha_y = alpha_y_prod[fppu_pkg::ALPHA_SHIFT +: PW];

   // snap test on offsets shifted down by 8, squares kept at full width
   assign dx8 = dx[PW-1:fppu_pkg::SNAP_SHIFT];
   assign dy8 = dy[PW-1:fppu_pkg::SNAP_SHIFT];
   assign dx_sq = dx8 * dx8;
   assign dy_sq = dy8 * dy8;
   assign dist_sq = {1'b0, dx_sq[SQ_W-2:0]} + {1'b0, dy_sq[SQ_W-2:0]};
   assign snap = (dist_sq < SQ_W'(cfg.snap_sq));

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      heading_in = heading_ff;
      unique case (item.mode)
         fppu_pkg::MODE_SET: begin
            x_in = item.value_x;
            y_in = item.value_y;
            heading_in = item.angle_value;
         end
         fppu_pkg::MODE_TRANSLATE: begin
            x_in = x_ff + item.value_x;
            y_in = y_ff + item.value_y;
         end
         fppu_pkg::MODE_ROTATE: begin
            heading_in = heading_ff + item.angle_value;
         end
         fppu_pkg::MODE_FORWARD: begin
            x_in = x_ff + trig_x;
            y_in = y_ff + trig_y;
         end
         fppu_pkg::MODE_SMOOTH: begin
            x_in = x_ff + alpha_x;
            y_in = y_ff + alpha_y;
         end
         fppu_pkg::MODE_ADAPTIVE: begin
            if (snap) begin
               x_in = item.value_x;
               y_in = item.value_y;
            end else begin
               x_in = x_ff + alpha_x;
               y_in = y_ff + alpha_y;
            end
         end
         fppu_pkg::MODE_DIRECTION: begin
            if (!item.direction[3]) begin
               x_in = x_ff + trig_x;
               y_in = y_ff + trig_y;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
         heading_ff <= '0;
      end else if (step_en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         heading_ff <= heading_in;
      end
   end

   assign pose.pos_x = x_ff;
   assign pose.pos_y = y_ff;
   assign pose.heading = heading_ff;

endmodule

// File: hw/rtl/fixed_point_pose_update_core.sv
// channel      dir  handshake        payload
// req_bus      in   valid / ready    mode, value_x, value_y, angle_value,
//                                    move_distance, direction
// rsp_bus      out  valid / ready    pos_x, pos_y, heading_out
// csr_*        in   write enable     csr_index (0 smooth_alpha, 1 snap_radius)
//
// one transaction per cycle sustained while rsp is ready; req passes the input and pose registers to rsp
// stage one is the input register, stage two the pose update whose registers
// are also the response payload (sine lookup, one multiplier level, one add)
// synchronous active-high reset zeroes the pose and both valid flags and
// loads the config reset values
// a stalled response holds the pose; the input register still takes a
// transaction when the response is being taken in the same cycle
module fixed_point_pose_update_core (
   input  logic                                 clock,
   input  logic                                 reset,
   fppu_req_if.sink                             req_bus,
   fppu_rsp_if.source                           rsp_bus,
   input  logic                                 csr_write_enable,
   input  logic [fppu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fppu_pkg::RADIUS_W-1:0]        csr_write_data
);

   // input stage
   fppu_pkg::item_type item_ff;
   logic               item_valid_ff;

   // response stage
   logic               rsp_valid_ff;
   logic               advance;

   // configuration; the snap radius is kept as its shifted square
   logic [fppu_pkg::ALPHA_W-1:0]   alpha_ff;
   logic [fppu_pkg::SNAP_SQ_W-1:0] snap_sq_ff, snap_sq_in;
   logic [fppu_pkg::RADIUS8_W-1:0] radius8;
   fppu_pkg::cfg_type              cfg;
   fppu_pkg::pose_type             pose;

   // the pose stage moves when the response slot is free or being drained
   assign advance = item_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         item_valid_ff <= req_bus.valid;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         item_ff.mode          <= fppu_pkg::mode_type'(req_bus.mode);
         item_ff.value_x       <= req_bus.value_x;
         item_ff.value_y       <= req_bus.value_y;
         item_ff.angle_value   <= req_bus.angle_value;
         item_ff.move_distance <= req_bus.move_distance;
         item_ff.direction     <= req_bus.direction;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // square of the radius with its low 8 bits dropped, worked out at write
   assign radius8 = csr_write_data[fppu_pkg::RADIUS_W-1:fppu_pkg::SNAP_SHIFT];
   assign snap_sq_in = radius8 * radius8;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= fppu_pkg::ALPHA_RESET;
         snap_sq_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            fppu_pkg::CSR_SMOOTH_ALPHA: alpha_ff <= csr_write_data[fppu_pkg::ALPHA_W-1:0];
            fppu_pkg::CSR_SNAP_RADIUS:  snap_sq_ff <= snap_sq_in;
            default: begin
            end
         endcase
      end
   end

   assign cfg.smooth_alpha = alpha_ff;
   assign cfg.snap_sq = snap_sq_ff;

   // pose registers update exactly when a new response is loaded, so they
   // double as the response payload
   fppu_pose_unit u_pose (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .pose    (pose)
   );

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.pos_x = pose.pos_x;
   assign rsp_bus.pos_y = pose.pos_y;
   assign rsp_bus.heading_out = pose.heading;

endmodule
